// ----- src/palette_texture_span_pixel_defines.svh -----
// Assertion macros for the span pixel engine.
`ifndef PALETTE_TEXTURE_SPAN_PIXEL_DEFINES_SVH
`define PALETTE_TEXTURE_SPAN_PIXEL_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off while in reset.
`define PST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, off while in reset.
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PST_ASSERT_IMPL(lbl, ante, cons, msg)
`define PST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/pst_pkg.sv -----
`default_nettype none
package pst_pkg;

    localparam int TEX_ADDR_BITS = 16;

    typedef logic [TEX_ADDR_BITS-1:0] t_tex_addr;

    // Input op codes
    localparam logic [2:0] OP_LOAD_TEXEL   = 3'd0;
    localparam logic [2:0] OP_LOAD_PALETTE = 3'd1;
    localparam logic [2:0] OP_LOAD_BLEND   = 3'd2;
    localparam logic [2:0] OP_SPAN_START   = 3'd3;
    localparam logic [2:0] OP_PIXEL        = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_LOG_U       = 3'd0;
    localparam logic [2:0] CFG_LOG_V       = 3'd1;
    localparam logic [2:0] CFG_U_STEP      = 3'd2;
    localparam logic [2:0] CFG_V_STEP      = 3'd3;
    localparam logic [2:0] CFG_BLEND_MODE  = 3'd4;
    localparam logic [2:0] CFG_ADDR_MODE   = 3'd5;
    localparam logic [2:0] CFG_COLUMN_SIZE = 3'd6;

    // Blend modes
    localparam logic [1:0] BLEND_OPAQUE    = 2'd0;
    localparam logic [1:0] BLEND_MASKED    = 2'd1;
    localparam logic [1:0] BLEND_TRANS     = 2'd2;
    localparam logic [1:0] BLEND_TRANS_REV = 2'd3;

    // Address modes; the unused code behaves as the 16.16 mode
    localparam logic [1:0] AMODE_TILE      = 2'd0;
    localparam logic [1:0] AMODE_COLUMN    = 2'd1;
    localparam logic [1:0] AMODE_FIXED     = 2'd2;

    localparam logic [7:0] TEXEL_CLEAR     = 8'd255;

    typedef struct packed {
        logic [4:0]  log_u;
        logic [4:0]  log_v;
        logic [31:0] u_step;
        logic [31:0] v_step;
        logic [1:0]  blend_mode;
        logic [1:0]  addr_mode;
        logic [16:0] column_size;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  value;
        logic [7:0]  background;
    } t_item;

endpackage
`default_nettype wire

// ----- src/pst_ram.sv -----
`default_nettype none
module pst_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [0:(1 << ADDR_BITS)-1];

    // Hold the read data while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata <= r_mem[i_raddr];
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/pst_addr_gen.sv -----
`default_nettype none
module pst_addr_gen (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_start,
    input  wire logic                 i_step,
    input  wire logic [31:0]          i_coord_u,
    input  wire logic [31:0]          i_coord_v,
    input  wire pst_pkg::t_cfg        i_cfg,
    output pst_pkg::t_tex_addr        o_tex_addr
);

    logic [31:0]        r_u_acc, r_v_acc;
    pst_pkg::t_tex_addr r_tile_addr, n_tile_addr;
    pst_pkg::t_tex_addr r_col_addr,  n_col_addr;
    pst_pkg::t_tex_addr r_prod,      r_v_int;
    logic [31:0]        top_u, top_v, col_full, v_ext;
    logic signed [33:0] prod;
    pst_pkg::t_tex_addr tile_shift;

    // Top bits of the accumulators; zero when the log field is zero.
    always_comb begin
        top_u = (i_cfg.log_u == 5'd0) ? 32'd0 : (r_u_acc >> (6'd32 - {1'b0, i_cfg.log_u}));
        top_v = (i_cfg.log_v == 5'd0) ? 32'd0 : (r_v_acc >> (6'd32 - {1'b0, i_cfg.log_v}));
        tile_shift  = pst_pkg::t_tex_addr'(top_u) << i_cfg.log_v;
        n_tile_addr = tile_shift + pst_pkg::t_tex_addr'(top_v);
        col_full    = r_v_acc >> i_cfg.log_v;
        n_col_addr  = pst_pkg::t_tex_addr'(col_full);
        prod        = 34'($signed(r_u_acc[31:16])) * 34'($signed({1'b0, i_cfg.column_size}));
        v_ext       = 32'($signed(r_v_acc[31:16]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_acc <= 32'd0;
            r_v_acc <= 32'd0;
        end else if (i_start) begin
            r_u_acc <= i_coord_u;
            r_v_acc <= i_coord_v;
        end else if (i_step) begin
            r_u_acc <= r_u_acc + i_cfg.u_step;
            r_v_acc <= r_v_acc + i_cfg.v_step;
        end
    end

    // Register the partial addresses; the product is cut to the texture size.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tile_addr <= n_tile_addr;
            r_col_addr  <= n_col_addr;
            r_prod      <= pst_pkg::t_tex_addr'(prod);
            r_v_int     <= pst_pkg::t_tex_addr'(v_ext);
        end
    end

    always_comb begin
        unique case (i_cfg.addr_mode)
            pst_pkg::AMODE_TILE:   o_tex_addr = r_tile_addr;
            pst_pkg::AMODE_COLUMN: o_tex_addr = r_col_addr;
            default:               o_tex_addr = r_prod + r_v_int;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/palette_texture_span_pixel.sv -----
// Stage 4 loads each pixel result into the output register. Throughput:
// one item per cycle unless stalled; the texture, palette and translucency
// memories each give one read and one write per cycle in their own stage.
// Reset (synchronous, active low) clears the accumulators, the stage valid
// bits, the output valid flag and the configuration registers to their
// defaults; the tables hold no defined content until loaded.
`default_nettype none
`include "palette_texture_span_pixel_defines.svh"
module palette_texture_span_pixel (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_value,
    input  wire logic [31:0] i_coord_u,
    input  wire logic [31:0] i_coord_v,
    input  wire logic [7:0]  i_background,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_pixel,
    output logic             o_write_pixel
);

    pst_pkg::t_cfg      r_cfg;
    pst_pkg::t_item     r_it1, r_it2, r_it3, r_it4;
    logic               r_vld1, r_vld2, r_vld3, r_vld4;
    logic [7:0]         r_texel3, r_texel4, r_pal4;
    logic               r_out_valid;
    logic [7:0]         r_out_pixel;
    logic               r_out_write;

    logic               en, accept, s4_result;
    pst_pkg::t_item     in_item;
    pst_pkg::t_tex_addr tex_raddr;
    logic [7:0]         tex_q, pal_q, blend_q;
    logic [15:0]        blend_raddr;
    logic [7:0]         n_pixel;
    logic               n_write;

    // Configuration registers; unused indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log_u       <= 5'd6;
            r_cfg.log_v       <= 5'd6;
            r_cfg.u_step      <= 32'd0;
            r_cfg.v_step      <= 32'd0;
            r_cfg.blend_mode  <= pst_pkg::BLEND_OPAQUE;
            r_cfg.addr_mode   <= pst_pkg::AMODE_TILE;
            r_cfg.column_size <= 17'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pst_pkg::CFG_LOG_U:       r_cfg.log_u       <= i_cfg_data[4:0];
                pst_pkg::CFG_LOG_V:       r_cfg.log_v       <= i_cfg_data[4:0];
                pst_pkg::CFG_U_STEP:      r_cfg.u_step      <= i_cfg_data;
                pst_pkg::CFG_V_STEP:      r_cfg.v_step      <= i_cfg_data;
                pst_pkg::CFG_BLEND_MODE:  r_cfg.blend_mode  <= i_cfg_data[1:0];
                pst_pkg::CFG_ADDR_MODE:   r_cfg.addr_mode   <= i_cfg_data[1:0];
                pst_pkg::CFG_COLUMN_SIZE: r_cfg.column_size <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together. It halts only when the last
    // stage holds a pixel and the output register is full and stalled;
    // loads and bubbles keep flowing past a waiting result.
    assign s4_result = r_vld4 && (r_it4.op == pst_pkg::OP_PIXEL);
    assign en        = !(s4_result && r_out_valid && i_stall);
    assign o_stall   = !en;
    assign accept    = i_valid && en;

    assign in_item.op         = i_op;
    assign in_item.addr       = i_addr;
    assign in_item.value      = i_value;
    assign in_item.background = i_background;

    // Stage 1: address generation. The accumulators move on the transfer
    // itself, so the next pixel sees the stepped values right away.
    pst_addr_gen u_addr_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_start    (accept && (i_op == pst_pkg::OP_SPAN_START)),
        .i_step     (accept && (i_op == pst_pkg::OP_PIXEL)),
        .i_coord_u  (i_coord_u),
        .i_coord_v  (i_coord_v),
        .i_cfg      (r_cfg),
        .o_tex_addr (tex_raddr)
    );

    // Each table is written in the same stage that reads it, so loads and
    // pixels keep their order without forwarding.
    pst_ram #(
        .ADDR_BITS (pst_pkg::TEX_ADDR_BITS),
        .DATA_BITS (8)
    ) u_texture (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_vld1 && (r_it1.op == pst_pkg::OP_LOAD_TEXEL)),
        .i_waddr (pst_pkg::t_tex_addr'(r_it1.addr)),
        .i_wdata (r_it1.value),
        .i_raddr (tex_raddr),
        .o_rdata (tex_q)
    );

    // Stage 2: palette lookup on the texel.
    pst_ram #(
        .ADDR_BITS (8),
        .DATA_BITS (8)
    ) u_palette (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_vld2 && (r_it2.op == pst_pkg::OP_LOAD_PALETTE)),
        .i_waddr (r_it2.addr[7:0]),
        .i_wdata (r_it2.value),
        .i_raddr (tex_q),
        .o_rdata (pal_q)
    );

    // Stage 3: translucency lookup; reversed mode swaps the index halves.
    assign blend_raddr = (r_cfg.blend_mode == pst_pkg::BLEND_TRANS_REV)
                       ? {pal_q, r_it3.background}
                       : {r_it3.background, pal_q};

    pst_ram #(
        .ADDR_BITS (16),
        .DATA_BITS (8)
    ) u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_vld3 && (r_it3.op == pst_pkg::OP_LOAD_BLEND)),
        .i_waddr (r_it3.addr),
        .i_wdata (r_it3.value),
        .i_raddr (blend_raddr),
        .o_rdata (blend_q)
    );

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (en) begin
            r_vld1 <= accept;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    // Stage payload; advance with the pipeline.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it1    <= in_item;
            r_it2    <= r_it1;
            r_it3    <= r_it2;
            r_it4    <= r_it3;
            r_texel3 <= tex_q;
            r_texel4 <= r_texel3;
            r_pal4   <= pal_q;
        end
    end

    // Stage 4: masked texel writes nothing; translucent modes take the
    // blended value, the others the palette color.
    always_comb begin
        n_pixel = r_pal4;
        n_write = 1'b1;
        priority if ((r_cfg.blend_mode != pst_pkg::BLEND_OPAQUE) &&
                     (r_texel4 == pst_pkg::TEXEL_CLEAR)) begin
            n_pixel = 8'd0;
            n_write = 1'b0;
        end else if ((r_cfg.blend_mode == pst_pkg::BLEND_TRANS) ||
                     (r_cfg.blend_mode == pst_pkg::BLEND_TRANS_REV)) begin
            n_pixel = blend_q;
        end else begin
            n_pixel = r_pal4;
        end
    end

    // Output register: drop the result on transfer, load a new one when the
    // last stage carries a pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && s4_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && s4_result) begin
            r_out_pixel <= n_pixel;
            r_out_write <= n_write;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel       = r_out_pixel;
    assign o_write_pixel = r_out_write;

    // A new result only ever comes from a pixel item in the last stage.
    `PST_ASSERT_IMPL(a_result_from_pixel, $rose(r_out_valid), $past(s4_result), "result without pixel")
    // The input side stalls only behind a blocked result.
    `PST_ASSERT_IMPL(a_stall_cause, o_stall, o_valid && i_stall && s4_result, "stall without cause")
    // While stalled the pixel in the last stage stays put.
    `PST_ASSERT_NEXT(a_hold_last, o_stall, r_vld4 && $stable(r_it4), "last stage moved under stall")

endmodule
`default_nettype wire
